// ===== design/lbc_pkg.sv =====
`timescale 1ns / 1ps
package lbc_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int FUNC_W = 2;
    localparam int DEV_W  = 4;
    localparam int SEC_W  = 28;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;
    localparam int TAG_W  = DEV_W + SEC_W;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_func FN_GET     = 2'd0;
    localparam t_func FN_WRITE   = 2'd1;
    localparam t_func FN_RELEASE = 2'd2;
    localparam t_func FN_DONE    = 2'd3;

    localparam t_status ST_HIT     = 3'd0;
    localparam t_status ST_MISS    = 3'd1;
    localparam t_status ST_WAIT    = 3'd2;
    localparam t_status ST_NOBUF   = 3'd3;
    localparam t_status ST_NOTBUSY = 3'd4;
    localparam t_status ST_DONE    = 3'd5;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/lbc_in_if.sv =====
`timescale 1ns / 1ps
interface lbc_in_if
    import lbc_pkg::*;
;
    logic                valid;
    logic                ready;
    t_func               func;
    logic [DEV_W-1:0]    dev_id;
    logic [SEC_W-1:0]    sector_num;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output func, output dev_id, output sector_num,
                    output slot, input ready);
    modport sink   (input valid, input func, input dev_id, input sector_num,
                    input slot, output ready);
endinterface

// ===== design/lbc_out_if.sv =====
`timescale 1ns / 1ps
interface lbc_out_if
    import lbc_pkg::*;
;
    logic                valid;
    logic                ready;
    t_status             status;
    logic [SLOT_W-1:0]   slot_out;
    logic                need_read;
    logic                need_write;
    logic [DEV_W-1:0]    req_dev;
    logic [SEC_W-1:0]    req_sector;

    modport source (output valid, output status, output slot_out, output need_read,
                    output need_write, output req_dev, output req_sector, input ready);
    modport sink   (input valid, input status, input slot_out, input need_read,
                    input need_write, input req_dev, input req_sector, output ready);
endinterface

// ===== design/lbc_ram.sv =====
`timescale 1ns / 1ps
module lbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/lbc_ctrl.sv =====
`timescale 1ns / 1ps
module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== design/lbc_dp.sv =====
`timescale 1ns / 1ps
module lbc_dp
    import lbc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  t_func             i_func,
    input  logic [DEV_W-1:0]  i_dev_id,
    input  logic [SEC_W-1:0]  i_sector_num,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_valid,
    input  logic              i_ready,
    output t_status           o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic              o_need_read,
    output logic              o_need_write,
    output logic [DEV_W-1:0]  o_req_dev,
    output logic [SEC_W-1:0]  o_req_sector
);
    localparam int SW = $clog2(NUM_SLOTS);

    // latched request
    t_func             r_func;
    logic [DEV_W-1:0]  r_dev;
    logic [SEC_W-1:0]  r_sec;
    logic [SLOT_W-1:0] r_slot;

    // slot state
    logic [NUM_SLOTS-1:0] r_used;
    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] r_dv;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [SW-1:0]        r_rank [NUM_SLOTS];

    // scan
    logic [SW-1:0]    r_idx;
    logic [SW-1:0]    r_idx_d;
    logic             r_rd_v;
    logic [TAG_W-1:0] rd_tag;

    logic             r_fnd_v;
    logic [SW-1:0]    r_fnd;
    logic             r_fnd_busy;
    logic             r_fnd_dv;
    logic             r_vic_v;
    logic [SW-1:0]    r_vic;
    logic [SW-1:0]    r_vic_rank;
    logic             r_s_busy;
    logic [SW-1:0]    r_s_rank;
    logic [TAG_W-1:0] r_s_tag;

    // result
    logic              r_out_v;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot_out;
    logic              r_need_read;
    logic              r_need_write;
    logic [DEV_W-1:0]  r_req_dev;
    logic [SEC_W-1:0]  r_req_sec;

    logic              s_in_rng;
    logic [SW-1:0]     s_idx;
    logic              e_match;
    logic              e_cand;
    logic              e_is_s;

    t_status           n_status;
    logic [SLOT_W-1:0] n_slot_out;
    logic              n_need_read;
    logic              n_need_write;
    logic [DEV_W-1:0]  n_req_dev;
    logic [SEC_W-1:0]  n_req_sec;
    logic              act_hit;
    logic              act_miss;
    logic              act_done;
    logic              act_wr;
    logic              act_rel;

    assign s_in_rng = int'(r_slot) < NUM_SLOTS;
    assign s_idx    = SW'(r_slot);

    lbc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (act_miss),
        .i_waddr (r_vic),
        .i_wdata ({r_dev, r_sec}),
        .i_raddr (r_idx),
        .o_rdata (rd_tag)
    );

    assign e_match = r_used[r_idx_d] && (rd_tag == {r_dev, r_sec});
    assign e_cand  = !r_busy[r_idx_d] && !r_dirty[r_idx_d]
                     && (!r_vic_v || (r_rank[r_idx_d] > r_vic_rank));
    assign e_is_s  = s_in_rng && (r_idx_d == s_idx);

    assign o_sts.scan_last = r_idx == SW'(NUM_SLOTS - 1);
    assign o_sts.out_busy  = r_out_v && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_dev  <= i_dev_id;
            r_sec  <= i_sector_num;
            r_slot <= i_slot;
        end
        r_idx_d <= r_idx;
        if (r_rd_v) begin
            if (e_match) begin
                r_fnd      <= r_idx_d;
                r_fnd_busy <= r_busy[r_idx_d];
                r_fnd_dv   <= r_dv[r_idx_d];
            end
            if (e_cand) begin
                r_vic      <= r_idx_d;
                r_vic_rank <= r_rank[r_idx_d];
            end
            if (e_is_s) begin
                r_s_busy <= r_busy[r_idx_d];
                r_s_rank <= r_rank[r_idx_d];
                r_s_tag  <= rd_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_fnd_v <= 1'b0;
            r_vic_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.scan_step;
            if (i_cmd.capture) begin
                r_idx   <= '0;
                r_fnd_v <= 1'b0;
                r_vic_v <= 1'b0;
            end else begin
                if (i_cmd.scan_step && !o_sts.scan_last) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_v && e_match) begin
                    r_fnd_v <= 1'b1;
                end
                if (r_rd_v && e_cand) begin
                    r_vic_v <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_status     = ST_DONE;
        n_slot_out   = r_slot;
        n_need_read  = 1'b0;
        n_need_write = 1'b0;
        n_req_dev    = '0;
        n_req_sec    = '0;
        act_hit      = 1'b0;
        act_miss     = 1'b0;
        act_done     = 1'b0;
        act_wr       = 1'b0;
        act_rel      = 1'b0;
        if (r_func == FN_GET) begin
            if (r_fnd_v) begin
                n_slot_out = SLOT_W'(r_fnd);
                if (r_fnd_busy) begin
                    n_status = ST_WAIT;
                end else begin
                    n_status    = ST_HIT;
                    n_need_read = !r_fnd_dv;
                    n_req_dev   = r_dev;
                    n_req_sec   = r_sec;
                    act_hit     = i_cmd.exec;
                end
            end else if (r_vic_v) begin
                n_status    = ST_MISS;
                n_slot_out  = SLOT_W'(r_vic);
                n_need_read = 1'b1;
                n_req_dev   = r_dev;
                n_req_sec   = r_sec;
                act_miss    = i_cmd.exec;
            end else begin
                n_status   = ST_NOBUF;
                n_slot_out = '0;
            end
        end else if (!s_in_rng) begin
            n_status = ST_NOTBUSY;
        end else if (r_func == FN_DONE) begin
            act_done = i_cmd.exec;
        end else if (!r_s_busy) begin
            n_status = ST_NOTBUSY;
        end else if (r_func == FN_WRITE) begin
            n_need_write = 1'b1;
            n_req_dev    = r_s_tag[TAG_W-1 -: DEV_W];
            n_req_sec    = r_s_tag[SEC_W-1:0];
            act_wr       = i_cmd.exec;
        end else begin
            act_rel = i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_busy  <= '0;
            r_dv    <= '0;
            r_dirty <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rank[i] <= SW'(NUM_SLOTS - 1 - i);
            end
        end else begin
            if (act_hit) begin
                r_busy[r_fnd] <= 1'b1;
            end
            if (act_miss) begin
                r_used[r_vic]  <= 1'b1;
                r_busy[r_vic]  <= 1'b1;
                r_dv[r_vic]    <= 1'b0;
                r_dirty[r_vic] <= 1'b0;
            end
            if (act_done) begin
                r_dv[s_idx]    <= 1'b1;
                r_dirty[s_idx] <= 1'b0;
            end
            if (act_wr) begin
                r_dirty[s_idx] <= 1'b1;
            end
            if (act_rel) begin
                r_busy[s_idx] <= 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (SW'(i) == s_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_rank[i] < r_s_rank) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_slot_out   <= n_slot_out;
            r_need_read  <= n_need_read;
            r_need_write <= n_need_write;
            r_req_dev    <= n_req_dev;
            r_req_sec    <= n_req_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid      = r_out_v;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_need_read  = r_need_read;
    assign o_need_write = r_need_write;
    assign o_req_dev    = r_req_dev;
    assign o_req_sector = r_req_sec;
endmodule

// ===== design/lru_block_buffer_cache_core.sv =====
// LRU block buffer cache tag table. Every request beat (get, write, release,
// disk done) is taken only while the block is idle and then scans all
// NUM_SLOTS slots through the single read port of the tag RAM, one slot per
// cycle, so no new request is accepted until the last one is through; the
// result beat is held in an output register, so the next request may be
// accepted while it waits. Tags of a slot that no get has filled are not
// initialized; after reset slot 0 is least recent.
`timescale 1ns / 1ps
module lru_block_buffer_cache_core
    import lbc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lbc_in_if.sink    i_req,
    lbc_out_if.source o_rsp
);
    t_cmd cmd;
    t_sts sts;

    lbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lbc_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_dev_id     (i_req.dev_id),
        .i_sector_num (i_req.sector_num),
        .i_slot       (i_req.slot),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_slot_out   (o_rsp.slot_out),
        .o_need_read  (o_rsp.need_read),
        .o_need_write (o_rsp.need_write),
        .o_req_dev    (o_rsp.req_dev),
        .o_req_sector (o_rsp.req_sector)
    );
endmodule

// ===== design/lbc_chk.sv =====
`timescale 1ns / 1ps
module lbc_chk
    import lbc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_status           i_status,
    input logic [SLOT_W-1:0] i_slot_out,
    input logic              i_need_read,
    input logic              i_need_write,
    input logic [DEV_W-1:0]  i_req_dev,
    input logic [SEC_W-1:0]  i_req_sector
);
    logic out_beat_fields_zero;
    assign out_beat_fields_zero = !i_need_read && !i_need_write
                                  && (i_req_dev == '0) && (i_req_sector == '0);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
                                        && $stable(i_slot_out))
        else $error("result beat dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in progress");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_WAIT || i_status == ST_NOBUF
                        || i_status == ST_NOTBUSY) |-> out_beat_fields_zero)
        else $error("nonzero fields on a refused request");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_need_write || i_status == ST_DONE)
                        && (i_status != ST_MISS || i_need_read)
                        && (i_status != ST_NOBUF || i_slot_out == '0))
        else $error("disk request flags inconsistent with status");
endmodule

bind lru_block_buffer_cache_core lbc_chk u_lbc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot_out   (o_rsp.slot_out),
    .i_need_read  (o_rsp.need_read),
    .i_need_write (o_rsp.need_write),
    .i_req_dev    (o_rsp.req_dev),
    .i_req_sector (o_rsp.req_sector)
);

// ===== test/lru_block_buffer_cache_core_test.sv =====
`timescale 1ns / 1ps
module lru_block_buffer_cache_core_test;
    import lbc_pkg::*;

    localparam int SLOTS      = NUM_SLOTS_DEF;
    localparam int RAND_ITEMS = 400;
    localparam int LIMIT      = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int TAG_POOL   = 24;

    typedef struct packed {
        t_func             func;
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic              rd;
        logic              wr;
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
    } rsp_t;

    logic i_clk;
    logic i_rst_n;

    lbc_in_if  req_if ();
    lbc_out_if rsp_if ();

    lru_block_buffer_cache_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // cache state as the testbench sees it
    logic [DEV_W-1:0]  slot_dev    [SLOTS];
    logic [SEC_W-1:0]  slot_sec    [SLOTS];
    logic              slot_tagged [SLOTS];
    logic              slot_busy   [SLOTS];
    logic              slot_loaded [SLOTS];
    logic              slot_dirty  [SLOTS];
    int                slot_age    [SLOTS];

    req_t   req_backlog[$];
    rsp_t   awaited_rsp[$];
    req_t   held_req;
    req_t   tag_pool[TAG_POOL];

    int     send_idle_pct;
    int     rsp_stall_pct;
    logic   hold_req;
    int     hold_left;
    int     cycles;
    int     errors;
    int     beats_in;
    int     beats_out;
    int     stat_count[6];

    function automatic rsp_t cache_response(input req_t r);
        rsp_t p;
        int   hit;
        int   victim;
        int   s;
        p      = '0;
        hit    = -1;
        victim = -1;
        s      = int'(r.slot);
        if (r.func == FN_GET) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_tagged[i] && slot_dev[i] == r.dev && slot_sec[i] == r.sec &&
                    (hit < 0 || slot_age[i] < slot_age[hit])) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                p.slot = SLOT_W'(hit);
                if (slot_busy[hit]) begin
                    p.status = ST_WAIT;
                end else begin
                    slot_busy[hit] = 1'b1;
                    p.status = ST_HIT;
                    p.rd     = !slot_loaded[hit];
                    p.dev    = slot_dev[hit];
                    p.sec    = slot_sec[hit];
                end
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_busy[i] && !slot_dirty[i] &&
                        (victim < 0 || slot_age[i] > slot_age[victim])) begin
                        victim = i;
                    end
                end
                if (victim < 0) begin
                    p.status = ST_NOBUF;
                end else begin
                    slot_dev[victim]    = r.dev;
                    slot_sec[victim]    = r.sec;
                    slot_tagged[victim] = 1'b1;
                    slot_busy[victim]   = 1'b1;
                    slot_loaded[victim] = 1'b0;
                    slot_dirty[victim]  = 1'b0;
                    p.status = ST_MISS;
                    p.slot   = SLOT_W'(victim);
                    p.rd     = 1'b1;
                    p.dev    = r.dev;
                    p.sec    = r.sec;
                end
            end
        end else begin
            p.slot   = r.slot;
            p.status = ST_NOTBUSY;
            if (s < SLOTS) begin
                if (r.func == FN_DONE) begin
                    slot_loaded[s] = 1'b1;
                    slot_dirty[s]  = 1'b0;
                    p.status = ST_DONE;
                end else if (slot_busy[s]) begin
                    p.status = ST_DONE;
                    if (r.func == FN_WRITE) begin
                        slot_dirty[s] = 1'b1;
                        p.wr  = 1'b1;
                        p.dev = slot_dev[s];
                        p.sec = slot_sec[s];
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (slot_age[i] < slot_age[s]) slot_age[i] = slot_age[i] + 1;
                        end
                        slot_age[s]  = 0;
                        slot_busy[s] = 1'b0;
                    end
                end
            end
        end
        return p;
    endfunction

    // picks a busy (or dirty) slot most of the time, using the current cache view
    function automatic logic [SLOT_W-1:0] pick_slot(input bit want_dirty);
        int cand[$];
        for (int i = 0; i < SLOTS; i++) begin
            if (want_dirty ? slot_dirty[i] : slot_busy[i]) cand.push_back(i);
        end
        if (cand.size() == 0 || $urandom_range(0, 9) == 0) return SLOT_W'($urandom);
        return SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   roll;
        r.dev  = DEV_W'($urandom);
        r.sec  = SEC_W'($urandom);
        r.slot = SLOT_W'($urandom);
        roll   = $urandom_range(0, 99);
        if (roll < 40) begin
            r.func = FN_GET;
            if ($urandom_range(0, 4) != 0) begin
                r.dev = tag_pool[$urandom_range(0, TAG_POOL - 1)].dev;
                r.sec = tag_pool[$urandom_range(0, TAG_POOL - 1)].sec;
            end
        end else if (roll < 55) begin
            r.func = FN_WRITE;
            r.slot = pick_slot(1'b0);
        end else if (roll < 70) begin
            r.func = FN_DONE;
            r.slot = pick_slot($urandom_range(0, 9) < 6);
        end else begin
            r.func = FN_RELEASE;
            r.slot = pick_slot(1'b0);
        end
        return r;
    endfunction

    function automatic req_t make_req(t_func f, logic [DEV_W-1:0] d, logic [SEC_W-1:0] s,
                                      logic [SLOT_W-1:0] sl);
        req_t r;
        r.func = f;
        r.dev  = d;
        r.sec  = s;
        r.slot = sl;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || req_if.valid || awaited_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        logic take;
        req_t nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            take = req_if.valid && req_if.ready;
            if (take) begin
                awaited_rsp.push_back(cache_response(held_req));
                beats_in++;
            end
            if (!req_if.valid || take) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = req_backlog.pop_front();
                    held_req          <= nxt;
                    req_if.func       <= nxt.func;
                    req_if.dev_id     <= nxt.dev;
                    req_if.sector_num <= nxt.sec;
                    req_if.slot       <= nxt.slot;
                    req_if.valid      <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        rsp_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            beats_out++;
            if (rsp_if.status < 6) stat_count[rsp_if.status]++;
            if (awaited_rsp.size() == 0) begin
                $error("response beat with nothing outstanding: status %0d slot %0d",
                       rsp_if.status, rsp_if.slot_out);
                errors++;
            end else begin
                want = awaited_rsp.pop_front();
                check_field("status", want.status, rsp_if.status);
                check_field("slot_out", want.slot, rsp_if.slot_out);
                check_field("need_read", want.rd, rsp_if.need_read);
                check_field("need_write", want.wr, rsp_if.need_write);
                check_field("req_dev", want.dev, rsp_if.req_dev);
                check_field("req_sector", want.sec, rsp_if.req_sector);
            end
        end
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAIL lru_block_buffer_cache_core");
            $finish;
        end
    end

    initial begin
        int send_pct[4];
        int stall_pct[4];
        send_pct  = '{0, 56, 0, 10};
        stall_pct = '{0, 0, 56, 10};

        req_if.valid      = 1'b0;
        req_if.func       = FN_GET;
        req_if.dev_id     = '0;
        req_if.sector_num = '0;
        req_if.slot       = '0;
        rsp_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        cycles            = 0;
        errors            = 0;
        beats_in          = 0;
        beats_out         = 0;
        send_idle_pct     = 0;
        rsp_stall_pct     = 0;
        held_req          = '0;
        stat_count        = '{default: 0};
        for (int i = 0; i < SLOTS; i++) begin
            slot_dev[i]    = '0;
            slot_sec[i]    = '0;
            slot_tagged[i] = 1'b0;
            slot_busy[i]   = 1'b0;
            slot_loaded[i] = 1'b0;
            slot_dirty[i]  = 1'b0;
            slot_age[i]    = SLOTS - 1 - i;
        end
        for (int k = 0; k < TAG_POOL; k++) begin
            tag_pool[k].dev = DEV_W'($urandom);
            tag_pool[k].sec = (k % 3 == 0) ? SEC_W'(28'h0123456) : SEC_W'($urandom);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: errors on idle slots, full get/write/done/release cycle, then exhaustion
        req_backlog.push_back(make_req(FN_WRITE, 4'h0, '0, 4'd3));
        req_backlog.push_back(make_req(FN_RELEASE, 4'h0, '0, 4'd15));
        req_backlog.push_back(make_req(FN_GET, 4'h0, 28'h0000000, 4'd0));
        req_backlog.push_back(make_req(FN_GET, 4'h0, 28'h0000000, 4'd0));
        req_backlog.push_back(make_req(FN_WRITE, 4'h0, '0, 4'd0));
        req_backlog.push_back(make_req(FN_DONE, 4'h0, '0, 4'd0));
        req_backlog.push_back(make_req(FN_RELEASE, 4'h0, '0, 4'd0));
        req_backlog.push_back(make_req(FN_GET, 4'h0, 28'h0000000, 4'd0));
        req_backlog.push_back(make_req(FN_GET, 4'hF, 28'hFFFFFFF, 4'hF));
        req_backlog.push_back(make_req(FN_RELEASE, 4'hF, 28'hFFFFFFF, 4'd1));
        req_backlog.push_back(make_req(FN_GET, 4'hF, 28'hFFFFFFF, 4'hF));
        req_backlog.push_back(make_req(FN_DONE, 4'h0, '0, 4'd7));
        for (int k = 0; k < SLOTS - 2; k++) begin
            req_backlog.push_back(make_req(FN_GET, DEV_W'(k + 1),
                                           (k % 2) ? 28'h5555555 : 28'hAAAAAAA, 4'h0));
        end
        req_backlog.push_back(make_req(FN_GET, 4'h0, 28'h0000001, 4'h0));
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            rsp_stall_pct = stall_pct[ph];
            for (int n = 0; n < RAND_ITEMS; n++) begin
                while (req_backlog.size() >= 2) @(negedge i_clk);
                req_backlog.push_back(random_req());
                if (n == 40 && (ph == 0 || ph == 3)) begin
                    hold_req = 1'b1;
                    @(negedge i_clk);
                    hold_req = 1'b0;
                end
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        $display("Covered %0d request beats, %0d response beats", beats_in, beats_out);
        $display("hit %0d, miss %0d, wait %0d, no buffer %0d, not busy %0d, done %0d",
                 stat_count[ST_HIT], stat_count[ST_MISS], stat_count[ST_WAIT],
                 stat_count[ST_NOBUF], stat_count[ST_NOTBUSY], stat_count[ST_DONE]);
        if (errors == 0 && awaited_rsp.size() == 0) begin
            $display("PASS lru_block_buffer_cache_core");
        end else begin
            $display("FAIL lru_block_buffer_cache_core");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lbc_pkg.sv
design/lbc_in_if.sv
design/lbc_out_if.sv
design/lbc_ram.sv
design/lbc_ctrl.sv
design/lbc_dp.sv
design/lru_block_buffer_cache_core.sv
design/lbc_chk.sv
test/lru_block_buffer_cache_core_test.sv
